// ===== hdl/sfi_pkg.sv =====
package sfi_pkg;

   localparam int SFI_FRAMES   = 256;
   localparam int SFI_FFT_SIZE = 64;
   localparam int QUEUE_DEPTH  = 4;

   localparam int TIME_W   = 24;
   localparam int VALUE_W  = 24;
   localparam int FRAC_W   = 16;
   localparam int WEIGHT_W = FRAC_W + 1;
   localparam int DIV_W    = TIME_W + FRAC_W;

   localparam logic [2:0] CMD_WRITE_PERIODIC  = 3'd0;
   localparam logic [2:0] CMD_WRITE_APERIODIC = 3'd1;
   localparam logic [2:0] CMD_WRITE_PITCH     = 3'd2;
   localparam logic [2:0] CMD_QUERY_SPECTRUM  = 3'd3;
   localparam logic [2:0] CMD_QUERY_F0        = 3'd4;

   localparam logic CSR_FRAME_PERIOD  = 1'b0;
   localparam logic CSR_FRAMES_IN_USE = 1'b1;

   localparam logic [15:0] FRAME_PERIOD_RESET  = 16'd1280;
   localparam logic [8:0]  FRAMES_IN_USE_RESET = 9'd256;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_W);

   typedef enum logic [2:0] {
      OP_WRITE_PERIODIC,
      OP_WRITE_APERIODIC,
      OP_WRITE_PITCH,
      OP_QUERY_SPECTRUM,
      OP_QUERY_F0,
      OP_SIZE_MISMATCH
   } op_kind_type;

   typedef struct packed {
      logic        valid;
      op_kind_type kind;
      logic [5:0]  bin;
      logic        last;
   } tag_type;

endpackage

// ===== hdl/spectral_frame_interpolator_top.sv =====
// Spectral frame interpolator. Requests load a periodic spectrogram, an aperiodicity
// spectrogram and an f0 contour, or query them at a time in ms (Q16.8). A front end
// takes one request at a time: a write passes accept and hand-off, a query passes accept,
// 40 steps of a bit-serial divider that yields the frame index and the Q0.16 weight in
// one pass, locate and hand-off; the next request waits until the last is handed off.
// A 4-entry queue feeds the back end, which performs writes as it takes them and streams
// a spectrum query as FFT_SIZE/2+1 results, one bin per cycle while the response is not
// stalled, through a six-stage datapath around two-port stores. A size mismatch or an
// f0 query gives one result. The queue lets the front end keep working while a result
// waits.
module spectral_frame_interpolator_top
   import sfi_pkg::*;
#(
   parameter int FRAMES = SFI_FRAMES,
   parameter int FFT_SIZE = SFI_FFT_SIZE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [7:0]         req_frame,
   input  logic [5:0]         req_bin,
   input  logic signed [23:0] req_value,
   input  logic [23:0]        req_time_ms,
   input  logic [15:0]        req_fft_size_asked,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic [5:0]         rsp_bin_index,
   output logic [23:0]        rsp_periodic_mag,
   output logic [15:0]        rsp_aperiodic_power,
   output logic signed [23:0] rsp_f0_value,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int NB = FFT_SIZE / 2 + 1;
   localparam int AW = $clog2(FRAMES * NB);
   localparam int KW = $bits(op_kind_type);
   localparam int QW = KW + 2 * AW + VALUE_W + WEIGHT_W;

   logic                  f_valid;
   logic                  f_ready;
   op_kind_type           f_kind;
   logic [AW-1:0]         f_addr_a;
   logic [AW-1:0]         f_addr_b;
   logic [VALUE_W-1:0]    f_value;
   logic [WEIGHT_W-1:0]   f_weight;

   logic                  b_valid;
   logic                  b_ready;
   logic [KW-1:0]         b_kind_raw;
   logic [AW-1:0]         b_addr_a;
   logic [AW-1:0]         b_addr_b;
   logic [VALUE_W-1:0]    b_value;
   logic [WEIGHT_W-1:0]   b_weight;

   logic [QW-1:0]         q_in_data;
   logic [QW-1:0]         q_out_data;

   sfi_front #(
      .FRAMES   (FRAMES),
      .FFT_SIZE (FFT_SIZE)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_frame          (req_frame),
      .req_bin            (req_bin),
      .req_value          (req_value),
      .req_time_ms        (req_time_ms),
      .req_fft_size_asked (req_fft_size_asked),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .op_valid           (f_valid),
      .op_ready           (f_ready),
      .op_kind            (f_kind),
      .op_addr_a          (f_addr_a),
      .op_addr_b          (f_addr_b),
      .op_value           (f_value),
      .op_weight          (f_weight)
   );

   assign q_in_data = {f_kind, f_addr_a, f_addr_b, f_value, f_weight};

   sfi_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out_data)
   );

   assign {b_kind_raw, b_addr_a, b_addr_b, b_value, b_weight} = q_out_data;

   sfi_back #(
      .FRAMES   (FRAMES),
      .FFT_SIZE (FFT_SIZE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .op_valid            (b_valid),
      .op_ready            (b_ready),
      .op_kind             (op_kind_type'(b_kind_raw)),
      .op_addr_a           (b_addr_a),
      .op_addr_b           (b_addr_b),
      .op_value            (b_value),
      .op_weight           (b_weight),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_bin_index       (rsp_bin_index),
      .rsp_periodic_mag    (rsp_periodic_mag),
      .rsp_aperiodic_power (rsp_aperiodic_power),
      .rsp_f0_value        (rsp_f0_value),
      .rsp_last            (rsp_last)
   );

endmodule

// ===== hdl/sfi_front.sv =====
module sfi_front
   import sfi_pkg::*;
#(
   parameter int FRAMES = SFI_FRAMES,
   parameter int FFT_SIZE = SFI_FFT_SIZE,
   localparam int NB = FFT_SIZE / 2 + 1,
   localparam int FW = $clog2(FRAMES),
   localparam int AW = $clog2(FRAMES * NB)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_command,
   input  logic [7:0]                req_frame,
   input  logic [5:0]                req_bin,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [TIME_W-1:0]         req_time_ms,
   input  logic [15:0]               req_fft_size_asked,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [15:0]               csr_wdata,
   output logic                      op_valid,
   input  logic                      op_ready,
   output op_kind_type               op_kind,
   output logic [AW-1:0]             op_addr_a,
   output logic [AW-1:0]             op_addr_b,
   output logic [VALUE_W-1:0]        op_value,
   output logic [WEIGHT_W-1:0]       op_weight
);

   localparam int STEP_W = $clog2(DIV_W);

   typedef enum logic [3:0] {
      F_IDLE   = 4'b0001,
      F_DIVIDE = 4'b0010,
      F_LOCATE = 4'b0100,
      F_PUSH   = 4'b1000
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [15:0]           frame_period_ff, frame_period_in;
   logic [8:0]            frames_in_use_ff, frames_in_use_in;
   op_kind_type           kind_ff, kind_in;
   logic [AW-1:0]         addr_a_ff, addr_a_in;
   logic [AW-1:0]         addr_b_ff, addr_b_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [DIV_W-1:0]      dq_ff, dq_in;
   logic [15:0]           rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic [15:0]           period;
   logic [FW-1:0]         last_frame;
   logic                  frame_ok;
   logic                  bin_ok;
   logic [AW-1:0]         write_addr;
   logic [16:0]           partial;
   logic [16:0]           diff;
   logic                  fits;
   logic [TIME_W-1:0]     quot;
   logic [FRAC_W-1:0]     frac;
   logic                  beyond_end;
   logic                  rem_nonzero;
   logic [FW-1:0]         q_frame;
   logic [FW-1:0]         lo_frame;
   logic [FW-1:0]         hi_frame;

   assign req_ready = (state_ff == F_IDLE);
   assign op_valid  = (state_ff == F_PUSH);
   assign op_kind   = kind_ff;
   assign op_addr_a = addr_a_ff;
   assign op_addr_b = addr_b_ff;
   assign op_value  = value_ff;
   assign op_weight = weight_ff;

   assign period = (frame_period_ff == 16'd0) ? 16'd1 : frame_period_ff;

   always_comb begin
      if (frames_in_use_ff == 9'd0) begin
         last_frame = '0;
      end else if (32'(frames_in_use_ff) > FRAMES) begin
         last_frame = FW'(FRAMES - 1);
      end else begin
         last_frame = FW'(frames_in_use_ff - 9'd1);
      end
   end

   assign frame_ok   = 32'(req_frame) < FRAMES;
   assign bin_ok     = 32'(req_bin) < NB;
   assign write_addr = AW'(AW'(req_frame) * AW'(NB)) + AW'(req_bin);

   // restoring division of time * 2^16 by the period, one quotient bit a step
   assign partial = {rem_ff, dq_ff[DIV_W-1]};
   assign diff    = partial - {1'b0, period};
   assign fits    = partial >= {1'b0, period};

   assign quot        = dq_ff[DIV_W-1 -: TIME_W];
   assign frac        = dq_ff[FRAC_W-1:0];
   assign beyond_end  = quot > TIME_W'(last_frame);
   assign rem_nonzero = (frac != '0) || (rem_ff != 16'd0);
   assign q_frame     = FW'(quot);
   assign lo_frame    = beyond_end ? last_frame : q_frame;
   assign hi_frame    = beyond_end ? last_frame :
                        ((rem_nonzero && (q_frame != last_frame)) ? q_frame + FW'(1) : q_frame);

   always_comb begin
      state_in         = state_ff;
      frame_period_in  = frame_period_ff;
      frames_in_use_in = frames_in_use_ff;
      kind_in          = kind_ff;
      addr_a_in        = addr_a_ff;
      addr_b_in        = addr_b_ff;
      value_in         = value_ff;
      weight_in        = weight_ff;
      dq_in            = dq_ff;
      rem_in           = rem_ff;
      step_in          = step_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_PERIOD: begin
               frame_period_in = csr_wdata;
            end
            CSR_FRAMES_IN_USE: begin
               frames_in_use_in = csr_wdata[8:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               case (req_command)
                  CMD_WRITE_PERIODIC, CMD_WRITE_APERIODIC: begin
                     if (frame_ok && bin_ok) begin
                        kind_in   = (req_command == CMD_WRITE_PERIODIC) ?
                                    OP_WRITE_PERIODIC : OP_WRITE_APERIODIC;
                        addr_a_in = write_addr;
                        state_in  = F_PUSH;
                     end
                  end
                  CMD_WRITE_PITCH: begin
                     if (frame_ok) begin
                        kind_in   = OP_WRITE_PITCH;
                        addr_a_in = AW'(req_frame);
                        state_in  = F_PUSH;
                     end
                  end
                  CMD_QUERY_SPECTRUM: begin
                     if (req_fft_size_asked != 16'(FFT_SIZE)) begin
                        kind_in  = OP_SIZE_MISMATCH;
                        state_in = F_PUSH;
                     end else begin
                        kind_in  = OP_QUERY_SPECTRUM;
                        dq_in    = {req_time_ms, FRAC_W'(0)};
                        rem_in   = 16'd0;
                        step_in  = '0;
                        state_in = F_DIVIDE;
                     end
                  end
                  CMD_QUERY_F0: begin
                     kind_in  = OP_QUERY_F0;
                     dq_in    = {req_time_ms, FRAC_W'(0)};
                     rem_in   = 16'd0;
                     step_in  = '0;
                     state_in = F_DIVIDE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         F_DIVIDE: begin
            dq_in   = {dq_ff[DIV_W-2:0], fits};
            rem_in  = fits ? diff[15:0] : partial[15:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               state_in = F_LOCATE;
            end
         end
         F_LOCATE: begin
            weight_in = beyond_end ? WEIGHT_ONE : {1'b0, frac};
            if (kind_ff == OP_QUERY_SPECTRUM) begin
               addr_a_in = AW'(AW'(lo_frame) * AW'(NB));
               addr_b_in = AW'(AW'(hi_frame) * AW'(NB));
            end else begin
               addr_a_in = AW'(lo_frame);
               addr_b_in = AW'(hi_frame);
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (op_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= F_IDLE;
         frame_period_ff  <= FRAME_PERIOD_RESET;
         frames_in_use_ff <= FRAMES_IN_USE_RESET;
      end else begin
         state_ff         <= state_in;
         frame_period_ff  <= frame_period_in;
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      value_ff  <= value_in;
      weight_ff <= weight_in;
      dq_ff     <= dq_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
   end

endmodule

// ===== hdl/sfi_queue.sv =====
module sfi_queue
   import sfi_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== hdl/sfi_back.sv =====
module sfi_back
   import sfi_pkg::*;
#(
   parameter int FRAMES = SFI_FRAMES,
   parameter int FFT_SIZE = SFI_FFT_SIZE,
   localparam int NB = FFT_SIZE / 2 + 1,
   localparam int FW = $clog2(FRAMES),
   localparam int AW = $clog2(FRAMES * NB)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      op_valid,
   output logic                      op_ready,
   input  op_kind_type               op_kind,
   input  logic [AW-1:0]             op_addr_a,
   input  logic [AW-1:0]             op_addr_b,
   input  logic [VALUE_W-1:0]        op_value,
   input  logic [WEIGHT_W-1:0]       op_weight,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic [5:0]                rsp_bin_index,
   output logic [23:0]               rsp_periodic_mag,
   output logic [15:0]               rsp_aperiodic_power,
   output logic signed [23:0]        rsp_f0_value,
   output logic                      rsp_last
);

   localparam int DEPTH = FRAMES * NB;
   localparam int BW    = $clog2(NB);
   localparam int OPW   = VALUE_W + 1;
   localparam int MW    = OPW + WEIGHT_W + 1;

   typedef enum logic [1:0] {
      B_IDLE  = 2'b01,
      B_ISSUE = 2'b10
   } back_state_type;

   function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] x);
      magnitude = x[VALUE_W-1] ? (~x + VALUE_W'(1)) : x;
   endfunction

   // aperiodicity held to [0.001, ~1]
   function automatic logic [15:0] clamp_ap(input logic [VALUE_W-1:0] x);
      logic signed [VALUE_W-1:0] s;
      s = $signed(x);
      if (s < $signed(VALUE_W'(66))) begin
         clamp_ap = 16'd66;
      end else if (s > $signed(VALUE_W'(65535))) begin
         clamp_ap = 16'hFFFF;
      end else begin
         clamp_ap = x[15:0];
      end
   endfunction

   back_state_type        state_ff, state_in;
   op_kind_type           kind_ff, kind_in;
   logic [AW-1:0]         base_a_ff, base_a_in;
   logic [AW-1:0]         base_b_ff, base_b_in;
   logic [WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [BW-1:0]         bin_ff, bin_in;

   logic                  advance;
   logic                  issue_last;
   logic [AW-1:0]         rd_addr_a;
   logic [AW-1:0]         rd_addr_b;
   logic                  wr_per;
   logic                  wr_ap;
   logic                  wr_pitch;

   logic [VALUE_W-1:0]    per_mem   [DEPTH];
   logic [VALUE_W-1:0]    ap_mem    [DEPTH];
   logic [VALUE_W-1:0]    pitch_mem [FRAMES];

   tag_type               tag1_ff, tag1_in, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic [WEIGHT_W-1:0]   w1_ff;
   logic [VALUE_W-1:0]    per_a_ff, per_b_ff, ap_a_ff, ap_b_ff, pit_a_ff, pit_b_ff;

   logic signed [OPW-1:0] opa_ff, opa_in, opb_ff, opb_in;
   logic [15:0]           apa_ff, apb_ff;
   logic [WEIGHT_W-1:0]   wa_ff, wb_ff;

   logic signed [MW-1:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic [32:0]           aa_ff, aa_in, ab_ff, ab_in;

   logic signed [MW-1:0]  mix_sum;
   logic [23:0]           res4_ff, res4_in;
   logic [31:0]           aps_ff, aps_in;

   logic [63:0]           sq_ff, sq_in;
   logic [23:0]           res5_ff;
   logic [63:0]           pw_sum;

   logic                  rsp_valid_ff;
   logic                  rsp_status_ff, rsp_status_in;
   logic [5:0]            rsp_bin_ff, rsp_bin_in;
   logic [23:0]           rsp_mag_ff, rsp_mag_in;
   logic [15:0]           rsp_power_ff, rsp_power_in;
   logic [23:0]           rsp_f0_ff, rsp_f0_in;
   logic                  rsp_last_ff, rsp_last_in;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign op_ready   = (state_ff == B_IDLE);
   assign issue_last = (kind_ff != OP_QUERY_SPECTRUM) || (bin_ff == BW'(NB - 1));
   assign rd_addr_a  = base_a_ff + AW'(bin_ff);
   assign rd_addr_b  = base_b_ff + AW'(bin_ff);
   assign wr_per     = op_valid && op_ready && (op_kind == OP_WRITE_PERIODIC);
   assign wr_ap      = op_valid && op_ready && (op_kind == OP_WRITE_APERIODIC);
   assign wr_pitch   = op_valid && op_ready && (op_kind == OP_WRITE_PITCH);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      base_a_in = base_a_ff;
      base_b_in = base_b_ff;
      weight_in = weight_ff;
      bin_in    = bin_ff;
      case (state_ff)
         B_IDLE: begin
            if (op_valid && (op_kind == OP_QUERY_SPECTRUM || op_kind == OP_QUERY_F0 ||
                             op_kind == OP_SIZE_MISMATCH)) begin
               kind_in   = op_kind;
               base_a_in = op_addr_a;
               base_b_in = op_addr_b;
               weight_in = op_weight;
               bin_in    = '0;
               state_in  = B_ISSUE;
            end
         end
         B_ISSUE: begin
            if (advance) begin
               bin_in = bin_ff + BW'(1);
               if (issue_last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      base_a_ff <= base_a_in;
      base_b_ff <= base_b_in;
      weight_ff <= weight_in;
      bin_ff    <= bin_in;
   end

   // stores: one write port, two registered read ports each
   always_ff @(posedge clock) begin
      if (wr_per) begin
         per_mem[op_addr_a] <= op_value;
      end
      if (advance) begin
         per_a_ff <= per_mem[rd_addr_a];
         per_b_ff <= per_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ap) begin
         ap_mem[op_addr_a] <= op_value;
      end
      if (advance) begin
         ap_a_ff <= ap_mem[rd_addr_a];
         ap_b_ff <= ap_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pitch) begin
         pitch_mem[op_addr_a[FW-1:0]] <= op_value;
      end
      if (advance) begin
         pit_a_ff <= pitch_mem[rd_addr_a[FW-1:0]];
         pit_b_ff <= pitch_mem[rd_addr_b[FW-1:0]];
      end
   end

   always_comb begin
      tag1_in.valid = (state_ff == B_ISSUE);
      tag1_in.kind  = kind_ff;
      tag1_in.bin   = 6'(bin_ff);
      tag1_in.last  = issue_last;
   end

   always_comb begin
      if (tag1_ff.kind == OP_QUERY_F0) begin
         opa_in = {pit_a_ff[VALUE_W-1], pit_a_ff};
         opb_in = {pit_b_ff[VALUE_W-1], pit_b_ff};
      end else begin
         opa_in = {1'b0, magnitude(per_a_ff)};
         opb_in = {1'b0, magnitude(per_b_ff)};
      end
   end

   assign ma_in = opa_ff * $signed({1'b0, wa_ff});
   assign mb_in = opb_ff * $signed({1'b0, wb_ff});
   assign aa_in = apa_ff * wa_ff;
   assign ab_in = apb_ff * wb_ff;

   assign mix_sum = ma_ff + mb_ff + MW'(32768);
   assign res4_in = mix_sum[FRAC_W +: 24];
   assign aps_in  = 32'(aa_ff + ab_ff);

   assign sq_in  = aps_ff * aps_ff;
   assign pw_sum = sq_ff + 64'h0000_8000_0000_0000;

   always_comb begin
      rsp_status_in = 1'b0;
      rsp_bin_in    = 6'd0;
      rsp_mag_in    = 24'd0;
      rsp_power_in  = 16'd0;
      rsp_f0_in     = 24'd0;
      rsp_last_in   = tag5_ff.last;
      case (tag5_ff.kind)
         OP_QUERY_SPECTRUM: begin
            rsp_bin_in   = tag5_ff.bin;
            rsp_mag_in   = res5_ff;
            rsp_power_in = pw_sum[63:48];
         end
         OP_QUERY_F0: begin
            rsp_f0_in = res5_ff;
         end
         OP_SIZE_MISMATCH: begin
            rsp_status_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         tag4_ff      <= '0;
         tag5_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         tag1_ff      <= tag1_in;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         tag4_ff      <= tag3_ff;
         tag5_ff      <= tag4_ff;
         rsp_valid_ff <= tag5_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w1_ff         <= weight_ff;
         opa_ff        <= opa_in;
         opb_ff        <= opb_in;
         apa_ff        <= clamp_ap(ap_a_ff);
         apb_ff        <= clamp_ap(ap_b_ff);
         wa_ff         <= WEIGHT_ONE - w1_ff;
         wb_ff         <= w1_ff;
         ma_ff         <= ma_in;
         mb_ff         <= mb_in;
         aa_ff         <= aa_in;
         ab_ff         <= ab_in;
         res4_ff       <= res4_in;
         aps_ff        <= aps_in;
         sq_ff         <= sq_in;
         res5_ff       <= res4_ff;
         rsp_status_ff <= rsp_status_in;
         rsp_bin_ff    <= rsp_bin_in;
         rsp_mag_ff    <= rsp_mag_in;
         rsp_power_ff  <= rsp_power_in;
         rsp_f0_ff     <= rsp_f0_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_bin_index       = rsp_bin_ff;
   assign rsp_periodic_mag    = rsp_mag_ff;
   assign rsp_aperiodic_power = rsp_power_ff;
   assign rsp_f0_value        = rsp_f0_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== hdl/sfi_checker.sv =====
module sfi_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_status,
   input logic [5:0]         rsp_bin_index,
   input logic [23:0]        rsp_periodic_mag,
   input logic [15:0]        rsp_aperiodic_power,
   input logic signed [23:0] rsp_f0_value,
   input logic               rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index) &&
         $stable(rsp_periodic_mag) && $stable(rsp_last))
      else $error("stalled result changed");

   // size mismatch is a lone result with empty fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && rsp_bin_index == 6'd0 &&
         rsp_periodic_mag == 24'd0 && rsp_aperiodic_power == 16'd0 && rsp_f0_value == 24'sd0)
      else $error("mismatch result malformed");

   // only spectrum results can be non-final
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_status && rsp_f0_value == 24'sd0)
      else $error("non-final result is not a spectrum bin");

   // bins of one query follow each other in order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         !rsp_valid || rsp_bin_index == 6'($past(rsp_bin_index) + 6'd1))
      else $error("bin sequence broken");

endmodule

bind spectral_frame_interpolator_top sfi_checker u_sfi_checker (.*);
